/* rtl/core/esc_pkg.sv */
// Shared types and constants for the epoch seconds to calendar converter.
// Holds the control word layout, the microcode program and the month table.
// No dependencies.
package esc_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [8:0]  DAYS_COMMON   = 9'd365;
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;
    localparam logic [11:0] FIRST_YEAR    = 12'd1970;
    localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
    localparam logic [3:0]  LAST_MONTH    = 4'd12;

    // Reciprocals of the odd parts of the divisors: q = (x * RECIP) >> shift, exact over
    // the operand range (day: x = secs >> 7, shift 35; hour: x = rem >> 4, shift 21;
    // minute: x = rem >> 2, shift 14).
    localparam logic [25:0] RECIP_DAY     = 26'd50903317;
    localparam logic [13:0] RECIP_HOUR    = 14'd9321;
    localparam logic [10:0] RECIP_MIN     = 11'd1093;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_SET_DAY,
        OP_SET_HOUR,
        OP_SET_MIN,
        OP_YEAR,
        OP_MONTH
    } op_t;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_WAIT_IN,
        COND_LOOP_YEAR,
        COND_LOOP_MONTH,
        COND_WAIT_OUT
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DIV_DAY  = 4'd1;
    localparam step_t STEP_SET_DAY  = 4'd2;
    localparam step_t STEP_DIV_HOUR = 4'd3;
    localparam step_t STEP_SET_HOUR = 4'd4;
    localparam step_t STEP_DIV_MIN  = 4'd5;
    localparam step_t STEP_SET_MIN  = 4'd6;
    localparam step_t STEP_YEAR     = 4'd7;
    localparam step_t STEP_MONTH    = 4'd8;
    localparam step_t STEP_EMIT     = 4'd9;

    typedef struct packed {
        op_t        op;
        div_sel_t   div_sel;
        cond_t      cond;
        step_t      target;
    } ctrl_t;

    typedef struct packed {
        logic year_more;
        logic month_more;
    } status_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

    // Microcode program: one control word per step.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        w = '{op: OP_NOP, div_sel: DIV_DAY, cond: COND_JUMP, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:     w = '{OP_LOAD,     DIV_DAY,  COND_WAIT_IN,    STEP_IDLE};
            STEP_DIV_DAY:  w = '{OP_DIV,      DIV_DAY,  COND_NEXT,       STEP_IDLE};
            STEP_SET_DAY:  w = '{OP_SET_DAY,  DIV_DAY,  COND_NEXT,       STEP_IDLE};
            STEP_DIV_HOUR: w = '{OP_DIV,      DIV_HOUR, COND_NEXT,       STEP_IDLE};
            STEP_SET_HOUR: w = '{OP_SET_HOUR, DIV_HOUR, COND_NEXT,       STEP_IDLE};
            STEP_DIV_MIN:  w = '{OP_DIV,      DIV_MIN,  COND_NEXT,       STEP_IDLE};
            STEP_SET_MIN:  w = '{OP_SET_MIN,  DIV_MIN,  COND_NEXT,       STEP_IDLE};
            STEP_YEAR:     w = '{OP_YEAR,     DIV_DAY,  COND_LOOP_YEAR,  STEP_YEAR};
            STEP_MONTH:    w = '{OP_MONTH,    DIV_DAY,  COND_LOOP_MONTH, STEP_MONTH};
            STEP_EMIT:     w = '{OP_NOP,      DIV_DAY,  COND_WAIT_OUT,   STEP_IDLE};
            default:       w = '{OP_NOP,      DIV_DAY,  COND_JUMP,       STEP_IDLE};
        endcase
        return w;
    endfunction

    // Days in a month, January is 1.
    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = leap ? FEB_LEAP_DAYS : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/esc_datapath.sv */
// Datapath of the calendar converter: reciprocal-multiply division by constants, year and month subtraction,
// result registers. Driven one control word per cycle while exec is high; uses esc_pkg.
module esc_datapath
    import esc_pkg::*;
(
    input  logic        aclk,
    input  ctrl_t       ctrl,
    input  logic        exec,
    input  logic [31:0] seconds_count,
    output status_t     status,
    output result_t     result
);

    logic [31:0] num_reg, num_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] day_reg, day_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;

    logic [50:0] prod_day;
    logic [26:0] prod_hour;
    logic [20:0] prod_min;
    logic [15:0] quo_calc;
    logic [31:0] back;
    logic [31:0] rem_calc;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15: drop the power of two,
    // then multiply by the reciprocal of the odd part
    assign prod_day  = {26'd0, num_reg[31:7]} * {25'd0, RECIP_DAY};
    assign prod_hour = {14'd0, num_reg[16:4]} * {13'd0, RECIP_HOUR};
    assign prod_min  = {11'd0, num_reg[11:2]} * {10'd0, RECIP_MIN};

    always_comb begin
        unique case (ctrl.div_sel)
            DIV_DAY: begin
                quo_calc = prod_day[50:35];
                back     = {16'd0, quo_reg} * {15'd0, SECS_PER_DAY};
            end
            DIV_HOUR: begin
                quo_calc = {10'd0, prod_hour[26:21]};
                back     = {16'd0, quo_reg} * {15'd0, SECS_PER_HOUR};
            end
            DIV_MIN: begin
                quo_calc = {9'd0, prod_min[20:14]};
                back     = {16'd0, quo_reg} * {15'd0, SECS_PER_MIN};
            end
            default: begin
                quo_calc = prod_day[50:35];
                back     = {16'd0, quo_reg} * {15'd0, SECS_PER_DAY};
            end
        endcase
    end

    assign rem_calc = num_reg - back;

    assign leap = (year_reg[1:0] == 2'b00);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = month_length(month_reg, leap);

    assign status.year_more  = (day_reg > {7'd0, ylen});
    assign status.month_more = (day_reg > {11'd0, mlen}) && (month_reg != LAST_MONTH);

    always_comb begin
        num_next    = num_reg;
        quo_next    = quo_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (exec) begin
            unique case (ctrl.op)
                OP_NOP: begin
                end
                OP_LOAD: begin
                    num_next = seconds_count;
                end
                OP_DIV: begin
                    quo_next = quo_calc;
                end
                OP_SET_DAY: begin
                    // keep the seconds within the day for the hour split
                    day_next = quo_reg + 16'd1;
                    num_next = rem_calc;
                end
                OP_SET_HOUR: begin
                    hour_next = quo_reg[4:0];
                    num_next  = rem_calc;
                end
                OP_SET_MIN: begin
                    minute_next = quo_reg[5:0];
                    second_next = rem_calc[5:0];
                    year_next   = FIRST_YEAR;
                    month_next  = 4'd1;
                end
                OP_YEAR: begin
                    if (status.year_more) begin
                        day_next  = day_reg - {7'd0, ylen};
                        year_next = year_reg + 12'd1;
                    end
                end
                OP_MONTH: begin
                    if (status.month_more) begin
                        day_next   = day_reg - {11'd0, mlen};
                        month_next = month_reg + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        day_reg    <= day_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
    end

    assign result.year   = year_reg;
    assign result.month  = month_reg;
    assign result.day    = day_reg[4:0];
    assign result.hour   = hour_reg;
    assign result.minute = minute_reg;
    assign result.second = second_reg;

endmodule

/* rtl/core/epoch_seconds_to_calendar.sv */
// Top level: epoch seconds to calendar date and time of day.
// Microcoded sequencer (step counter, program in esc_pkg) over esc_datapath.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[31:0] = seconds_count
// m_       out  m_tvalid/m_tready  m_tdata[39:0] = year,month,day,hour,minute,second
//
// An item is taken in the idle step, then passes through the three reciprocal divisions and their
// remainders, a year step and a month step per whole year or month stripped plus one each, and
// the emit step that hands it off. A new item is taken only once the sequencer is back at idle.
// Reset (aresetn low, synchronous) returns the step counter to idle, drops m_tvalid
// and holds s_tready low.
// The next item is taken while a result waits in the output register; a stalled
// m_tready holds the sequencer at its last step.
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seconds_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [11:0] year, [15:12] month, [20:16] day,
                                   // [25:21] hour, [31:26] minute, [37:32] second
);

    step_t   step_reg, step_next;
    ctrl_t   ctrl;
    status_t status;
    result_t result;
    result_t out_reg, out_next;
    logic    m_tvalid_reg, m_tvalid_next;
    logic    stall;
    logic    exec;
    step_t   step_inc;

    assign ctrl     = ucode(step_reg);
    assign step_inc = step_reg + 4'd1;

    assign stall = ((ctrl.cond == COND_WAIT_IN) && !s_tvalid)
                || ((ctrl.cond == COND_WAIT_OUT) && m_tvalid_reg && !m_tready);
    assign exec  = !stall;

    esc_datapath u_datapath (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .exec          (exec),
        .seconds_count (s_tdata),
        .status        (status),
        .result        (result)
    );

    always_comb begin
        step_next = step_reg;
        if (!stall) begin
            unique case (ctrl.cond)
                COND_NEXT:       step_next = step_inc;
                COND_JUMP:       step_next = ctrl.target;
                COND_WAIT_IN:    step_next = step_inc;
                COND_LOOP_YEAR:  step_next = status.year_more ? ctrl.target : step_inc;
                COND_LOOP_MONTH: step_next = status.month_more ? ctrl.target : step_inc;
                COND_WAIT_OUT:   step_next = ctrl.target;
                default:         step_next = STEP_IDLE;
            endcase
        end
    end

    always_comb begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        // hand the finished item to the output register
        if ((ctrl.cond == COND_WAIT_OUT) && exec) begin
            out_next      = result;
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign s_tready = aresetn && (ctrl.cond == COND_WAIT_IN);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.second, out_reg.minute, out_reg.hour,
                       out_reg.day, out_reg.month, out_reg.year};

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (step_reg == STEP_DIV_DAY))
        else $error("accepted item did not start the day division");

    a_step_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_EMIT)
        else $error("step counter left the program");

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.month >= 4'd1) && (out_reg.month <= LAST_MONTH)
                     && (out_reg.day != 5'd0) && (out_reg.hour < 5'd24)
                     && (out_reg.minute < 6'd60) && (out_reg.second < 6'd60))
        else $error("result field out of range");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((step_reg == STEP_EMIT) && m_tvalid && !m_tready) |=> (step_reg == STEP_EMIT))
        else $error("sequencer left the emit step while the output was stalled");

endmodule
